@@ rtl/core/smm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types, codes and field positions for the microprogrammed
// stack-machine datapath.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 512;
    localparam int unsigned WORD_BITS_DEF   = 32;

    localparam int unsigned UADDR_W = 9;
    localparam int unsigned MI_W    = 36;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned NREGS   = 9;

    // Stream payload layout.
    localparam int unsigned S_TUSER_W  = 2;
    localparam int unsigned S_ADDR_LSB = 0;
    localparam int unsigned S_WORD_LSB = S_ADDR_LSB + UADDR_W;
    localparam int unsigned S_MBR_LSB  = S_WORD_LSB + MI_W;
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_UADDR_LSB = NREGS * OUT_W;
    localparam int unsigned M_N_BIT     = M_UADDR_LSB + UADDR_W;
    localparam int unsigned M_Z_BIT     = M_N_BIT + 1;
    localparam int unsigned M_TDATA_W   = 304;

    // Microinstruction fields.
    localparam int unsigned MI_NEXT_LSB = 27;
    localparam int unsigned MI_JMPC     = 26;
    localparam int unsigned MI_JAMN     = 25;
    localparam int unsigned MI_JAMZ     = 24;
    localparam int unsigned MI_SLL8     = 23;
    localparam int unsigned MI_SRL1     = 22;
    localparam int unsigned MI_F0       = 21;
    localparam int unsigned MI_F1       = 20;
    localparam int unsigned MI_ENA      = 19;
    localparam int unsigned MI_ENB      = 18;
    localparam int unsigned MI_INVA     = 17;
    localparam int unsigned MI_INC      = 16;
    localparam int unsigned MI_CMASK_LSB = 7;
    localparam int unsigned MI_BSEL_LSB  = 0;

    // Register indices, in C-mask bit order.
    localparam int unsigned R_MAR = 0;
    localparam int unsigned R_MDR = 1;
    localparam int unsigned R_PC  = 2;
    localparam int unsigned R_SP  = 3;
    localparam int unsigned R_LV  = 4;
    localparam int unsigned R_CPP = 5;
    localparam int unsigned R_TOS = 6;
    localparam int unsigned R_OPC = 7;
    localparam int unsigned R_H   = 8;

    typedef enum logic [1:0] {
        ACT_STORE = 2'd0,
        ACT_MBR   = 2'd1,
        ACT_EXEC  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        BSEL_MDR  = 4'd0,
        BSEL_PC   = 4'd1,
        BSEL_MBR  = 4'd2,
        BSEL_MBRU = 4'd3,
        BSEL_SP   = 4'd4,
        BSEL_LV   = 4'd5,
        BSEL_CPP  = 4'd6,
        BSEL_TOS  = 4'd7,
        BSEL_OPC  = 4'd8
    } bsel_t;

    typedef enum logic [1:0] {
        ALU_AND = 2'd0,
        ALU_OR  = 2'd1,
        ALU_NOTB = 2'd2,
        ALU_ADD = 2'd3
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_mbr;
        logic execute;
        logic emit;
    } dp_cmd_t;

endpackage

@@ rtl/core/smm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/smm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ctrl
// Sequencer: input handshake, control store access and result beat control.
// ----------------------------------------------------------------------------
module smm_ctrl #(
    parameter int unsigned STORE_DEPTH = smm_pkg::STORE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [smm_pkg::S_TUSER_W-1:0]    action,
    input  logic [smm_pkg::UADDR_W-1:0]      store_address,
    input  logic [smm_pkg::UADDR_W-1:0]      upc,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             ram_wr_en,
    output logic [$clog2(STORE_DEPTH)-1:0]   ram_wr_addr,
    output logic                             ram_rd_en,
    output logic [$clog2(STORE_DEPTH)-1:0]   ram_rd_addr,
    output smm_pkg::dp_cmd_t                 cmd
);

    import smm_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam logic [13:0] DEPTH14 = 14'(STORE_DEPTH);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    // Addresses wrap at the store depth; the quotient is below 32 as long as
    // the depth is at least 16, so five compare-subtract steps suffice.
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [UADDR_W-1:0] a);
        logic [13:0] r;
        r = 14'(a);
        for (int k = 4; k >= 0; k--) begin
            if (r >= (DEPTH14 << k)) begin
                r = r - (DEPTH14 << k);
            end
        end
        return r[ADDR_W-1:0];
    endfunction

    assign out_free    = !m_tvalid_reg || m_tready;
    assign ram_wr_addr = wrap_addr(store_address);
    assign ram_rd_addr = wrap_addr(upc);
    assign m_tvalid    = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (action_t'(action))
                        ACT_STORE: ram_wr_en    = 1'b1;
                        ACT_MBR:   cmd.load_mbr = 1'b1;
                        ACT_EXEC:  ram_rd_en    = 1'b1;
                        ACT_NONE:  ;
                        default:   ;
                    endcase
                    if (action_t'(action) == ACT_EXEC) begin
                        state_next = ST_FETCH;
                    end else if (out_free) begin
                        cmd.emit = 1'b1;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // The read data stays in the RAM register until the result
                // beat has room, so the microcycle is applied only then.
                if (out_free) begin
                    cmd.execute = 1'b1;
                    cmd.emit    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result beat produced while the output slot is occupied");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && action == ACT_EXEC) |=> (state_reg == ST_FETCH))
        else $error("execute beat did not start a control store fetch");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |=> state_reg == ST_EXEC)
        else $error("fetch not followed by execute");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> $past(ram_rd_en, 2) || $past(state_reg == ST_EXEC))
        else $error("microcycle applied without a control store read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid_reg)
        else $error("result beat lost");

endmodule

@@ rtl/core/smm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_datapath
// Register file, B-bus select, ALU, shifter, flags, next-address logic and
// the result register.
// ----------------------------------------------------------------------------
module smm_datapath #(
    parameter int unsigned WORD_BITS = smm_pkg::WORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  smm_pkg::dp_cmd_t                cmd,
    input  logic [7:0]                      mbr_in,
    input  logic [smm_pkg::MI_W-1:0]        mi,
    output logic [smm_pkg::UADDR_W-1:0]     upc,
    output logic [smm_pkg::M_TDATA_W-1:0]   m_tdata
);

    import smm_pkg::*;

    logic [WORD_BITS-1:0] regs_reg  [NREGS];
    logic [WORD_BITS-1:0] regs_next [NREGS];
    logic [7:0]           mbr_reg, mbr_next;
    logic [UADDR_W-1:0]   upc_reg, upc_next;
    logic                 n_reg, n_next, z_reg, z_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic [WORD_BITS-1:0] b_bus, a_op, b_op, alu_res, shift_res;
    logic [NREGS-1:0]     cmask;
    logic                 alu_n, alu_z;
    logic [UADDR_W-1:0]   addr_calc;

    assign cmask = mi[MI_CMASK_LSB +: NREGS];

    always_comb begin
        unique case (bsel_t'(mi[MI_BSEL_LSB +: 4]))
            BSEL_MDR:  b_bus = regs_reg[R_MDR];
            BSEL_PC:   b_bus = regs_reg[R_PC];
            BSEL_MBR:  b_bus = {{(WORD_BITS-8){mbr_reg[7]}}, mbr_reg};
            BSEL_MBRU: b_bus = WORD_BITS'(mbr_reg);
            BSEL_SP:   b_bus = regs_reg[R_SP];
            BSEL_LV:   b_bus = regs_reg[R_LV];
            BSEL_CPP:  b_bus = regs_reg[R_CPP];
            BSEL_TOS:  b_bus = regs_reg[R_TOS];
            BSEL_OPC:  b_bus = regs_reg[R_OPC];
            default:   b_bus = '0;
        endcase
    end

    always_comb begin
        a_op = mi[MI_ENA] ? regs_reg[R_H] : '0;
        if (mi[MI_INVA]) begin
            a_op = ~a_op;
        end
        b_op = mi[MI_ENB] ? b_bus : '0;
        case (alu_op_t'({mi[MI_F0], mi[MI_F1]}))
            ALU_AND:  alu_res = a_op & b_op;
            ALU_OR:   alu_res = a_op | b_op;
            ALU_NOTB: alu_res = ~b_op;
            default:  alu_res = a_op + b_op + WORD_BITS'(mi[MI_INC]);
        endcase
    end

    assign alu_n = alu_res[WORD_BITS-1];
    assign alu_z = (alu_res == '0);

    always_comb begin
        case ({mi[MI_SLL8], mi[MI_SRL1]})
            2'b01:   shift_res = alu_res >> 1;
            2'b10:   shift_res = alu_res << 8;
            2'b11:   shift_res = (alu_res << 8) >> 1;
            default: shift_res = alu_res;
        endcase
    end

    // JAM: the high address bit is forced by the selected condition, and
    // JMPC merges the MBR byte into the low bits.
    always_comb begin
        addr_calc = mi[MI_NEXT_LSB +: UADDR_W];
        if ((mi[MI_JAMZ] && alu_z) || (mi[MI_JAMN] && alu_n)) begin
            addr_calc[UADDR_W-1] = 1'b1;
        end
        if (mi[MI_JMPC]) begin
            addr_calc = addr_calc | UADDR_W'(mbr_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < NREGS; i++) begin
            regs_next[i] = (cmd.execute && cmask[i]) ? shift_res : regs_reg[i];
        end
        mbr_next = cmd.load_mbr ? mbr_in : mbr_reg;
        upc_next = cmd.execute ? addr_calc : upc_reg;
        n_next   = cmd.execute ? alu_n : n_reg;
        z_next   = cmd.execute ? alu_z : z_reg;
    end

    always_comb begin
        out_next = '0;
        for (int i = 0; i < NREGS; i++) begin
            out_next[i*OUT_W +: OUT_W] = OUT_W'(regs_next[i]);
        end
        out_next[M_UADDR_LSB +: UADDR_W] = upc_next;
        out_next[M_N_BIT] = n_next;
        out_next[M_Z_BIT] = z_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NREGS; i++) begin
                regs_reg[i] <= '0;
            end
            mbr_reg <= '0;
            upc_reg <= '0;
            n_reg   <= 1'b0;
            z_reg   <= 1'b0;
        end else begin
            for (int i = 0; i < NREGS; i++) begin
                regs_reg[i] <= regs_next[i];
            end
            mbr_reg <= mbr_next;
            upc_reg <= upc_next;
            n_reg   <= n_next;
            z_reg   <= z_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg <= out_next;
        end
    end

    assign upc     = upc_reg;
    assign m_tdata = out_reg;

endmodule

@@ rtl/core/stack_machine_microcycle.sv @@
`timescale 1ns / 1ps
// A load beat is registered into its result beat on acceptance when the output slot is
// free, else from an emit wait state; an execute beat passes through the registered
// read of the control store, one wait state and the execute state. A new execute beat
// is taken only after the last one has left the execute state; load beats can
// be taken every cycle while the result side keeps accepting.
// Reset clears the datapath registers, MBR, microaddress and flags; the
// control store is not cleared and must be written before it is executed.
// ----------------------------------------------------------------------------
// stack_machine_microcycle
// Microprogrammed stack-machine datapath running one microcycle per
// execute beat, with a loadable control store.
// ----------------------------------------------------------------------------
module stack_machine_microcycle #(
    parameter int unsigned STORE_DEPTH = smm_pkg::STORE_DEPTH_DEF,
    parameter int unsigned WORD_BITS   = smm_pkg::WORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: store_address[8:0], store_word[44:9], mbr_value[52:45], zero fill
    input  logic [smm_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: action[1:0]
    input  logic [smm_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: mar, mdr, pc, sp, lv, cpp, tos, opc, h (32 bits each),
    // microaddress_out[296:288], negative_flag[297], zero_flag[298], zero fill
    output logic [smm_pkg::M_TDATA_W-1:0]  m_tdata
);

    import smm_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

    dp_cmd_t             cmd;
    logic [UADDR_W-1:0]  upc;
    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [MI_W-1:0]     mi;

    smm_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .action        (s_tuser),
        .store_address (s_tdata[S_ADDR_LSB +: UADDR_W]),
        .upc           (upc),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .cmd           (cmd)
    );

    smm_ram #(
        .WIDTH (MI_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata[S_WORD_LSB +: MI_W]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (mi)
    );

    smm_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .mbr_in  (s_tdata[S_MBR_LSB +: 8]),
        .mi      (mi),
        .upc     (upc),
        .m_tdata (m_tdata)
    );

endmodule

@@ tb/stack_machine_microcycle_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_microcycle_test
// Self-checking bench for the microprogrammed datapath. Microinstructions are
// loaded into the control store and then executed one microcycle at a time.
// A shadow copy of the registers, flags, MBR and microaddress predicts every
// result beat, and each beat is checked field by field as it arrives.
// ----------------------------------------------------------------------------
module stack_machine_microcycle_test;
    import smm_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // JAM bits, highest first: JMPC, JAMN, JAMZ.
    localparam logic [2:0] JAM_OFF = 3'b000;
    localparam logic [2:0] JAM_Z   = 3'b001;
    localparam logic [2:0] JAM_N   = 3'b010;
    localparam logic [2:0] JAM_C   = 3'b100;

    // Shifter bits: SLL8, SRL1.
    localparam logic [1:0] SH_NONE = 2'b00;
    localparam logic [1:0] SH_SRL1 = 2'b01;
    localparam logic [1:0] SH_SLL8 = 2'b10;
    localparam logic [1:0] SH_BOTH = 2'b11;

    // B-bus selects that drive nothing.
    localparam logic [3:0] BSEL_VOID_LO = 4'd9;
    localparam logic [3:0] BSEL_VOID_HI = 4'd15;

    // Same bit order as the low 299 bits of m_tdata.
    typedef struct packed {
        logic             zero;
        logic             neg;
        logic [8:0]       upc;
        logic [8:0][31:0] regs;
    } dp_view_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = ACT_NONE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    stack_machine_microcycle uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Shadow state of the datapath.
    logic [35:0]      ustore  [512];
    bit               written [512];
    logic [8:0][31:0] dp_reg  = '0;
    logic [7:0]       mbr_q   = '0;
    logic [8:0]       upc_q   = '0;
    logic             n_q     = 1'b0;
    logic             z_q     = 1'b0;

    dp_view_t pending_states [$];
    dp_view_t want, got;
    int       mismatches  = 0;
    int       sent_beats  = 0;
    int       quiet_cycles = 0;
    int       stall_left  = 0;
    bit       idle_en     = 1'b1;

    function automatic logic [35:0] rand36();
        return {4'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [35:0] uinstr(logic [8:0] nxt, logic [2:0] jam, logic [1:0] shf,
                                           alu_op_t op, logic ena, logic enb, logic inva,
                                           logic inc, logic [8:0] cmask, logic [3:0] bsel);
        return {nxt, jam, shf, op, ena, enb, inva, inc, cmask, 3'b000, bsel};
    endfunction

    // Half of the random microinstructions branch into a small region so that
    // stored entries get executed again.
    function automatic logic [35:0] random_uinstr();
        logic [35:0] w;
        w = rand36();
        if ($urandom_range(0, 1) == 1)
            w[35:MI_NEXT_LSB] = 9'($urandom_range(0, 31));
        return w;
    endfunction

    function automatic void advance_datapath(action_t act, logic [8:0] addr,
                                             logic [35:0] word, logic [7:0] mbr);
        logic [35:0] mi;
        logic [31:0] a, b, r;
        logic [8:0]  nxt;
        dp_view_t    v;
        case (act)
            ACT_STORE: begin
                ustore[addr]  = word;
                written[addr] = 1'b1;
            end
            ACT_MBR: mbr_q = mbr;
            ACT_EXEC: begin
                mi = ustore[upc_q];
                case (mi[3:0])
                    BSEL_MDR:  b = dp_reg[R_MDR];
                    BSEL_PC:   b = dp_reg[R_PC];
                    BSEL_MBR:  b = {{24{mbr_q[7]}}, mbr_q};
                    BSEL_MBRU: b = {24'd0, mbr_q};
                    BSEL_SP:   b = dp_reg[R_SP];
                    BSEL_LV:   b = dp_reg[R_LV];
                    BSEL_CPP:  b = dp_reg[R_CPP];
                    BSEL_TOS:  b = dp_reg[R_TOS];
                    BSEL_OPC:  b = dp_reg[R_OPC];
                    default:   b = '0;
                endcase
                if (!mi[MI_ENB])
                    b = '0;
                a = mi[MI_ENA] ? dp_reg[R_H] : '0;
                if (mi[MI_INVA])
                    a = ~a;
                case (alu_op_t'({mi[MI_F0], mi[MI_F1]}))
                    ALU_AND:  r = a & b;
                    ALU_OR:   r = a | b;
                    ALU_NOTB: r = ~b;
                    default:  r = a + b + 32'(mi[MI_INC]);
                endcase
                n_q = r[31];
                z_q = (r == '0);
                if (mi[MI_SLL8])
                    r = r << 8;
                if (mi[MI_SRL1])
                    r = r >> 1;
                for (int i = 0; i < NREGS; i++)
                    if (mi[MI_CMASK_LSB + i])
                        dp_reg[i] = r;
                nxt = mi[35:MI_NEXT_LSB];
                if ((mi[MI_JAMZ] && z_q) || (mi[MI_JAMN] && n_q))
                    nxt[8] = 1'b1;
                if (mi[MI_JMPC])
                    nxt = nxt | {1'b0, mbr_q};
                upc_q = nxt;
            end
            default: ;
        endcase
        v.zero = z_q;
        v.neg  = n_q;
        v.upc  = upc_q;
        v.regs = dp_reg;
        pending_states.push_back(v);
    endfunction

    task automatic send_beat(action_t act, logic [8:0] addr, logic [35:0] word,
                             logic [7:0] mbr);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, mbr, word, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_datapath(act, addr, word, mbr);
        sent_beats++;
    endtask

    task automatic exec_beat();
        send_beat(ACT_EXEC, 9'($urandom), rand36(), 8'($urandom));
    endtask

    // Places a microinstruction at the current microaddress and runs it.
    task automatic run_micro(logic [35:0] mi);
        send_beat(ACT_STORE, upc_q, mi, 8'($urandom));
        exec_beat();
    endtask

    task automatic test_reset_view();
        send_beat(ACT_NONE, 9'($urandom), rand36(), 8'($urandom));
    endtask

    task automatic test_alu_and_shifter();
        // All ones into every register; N set, so JAMN takes the high half.
        run_micro(uinstr(9'h005, JAM_N, SH_NONE, ALU_NOTB, 1'b0, 1'b0, 1'b0, 1'b0,
                         9'h1FF, BSEL_MDR));
        // Sign-extended MBR plus H plus carry, both shifts, JMPC on MBR.
        send_beat(ACT_MBR, 9'($urandom), rand36(), 8'h80);
        run_micro(uinstr(9'h000, JAM_C, SH_BOTH, ALU_ADD, 1'b1, 1'b1, 1'b0, 1'b1,
                         (9'b1 << R_TOS) | (9'b1 << R_H), BSEL_MBR));
        // AND with the zero-extended MBR gives zero, so JAMZ is taken.
        run_micro(uinstr(9'h011, JAM_Z, SH_SRL1, ALU_AND, 1'b1, 1'b1, 1'b0, 1'b0,
                         9'b1 << R_SP, BSEL_MBRU));
        // OR with inverted H, left shift by eight, last entry of the store.
        run_micro(uinstr(9'h1FF, JAM_OFF, SH_SLL8, ALU_OR, 1'b1, 1'b1, 1'b1, 1'b0,
                         (9'b1 << R_OPC) | (9'b1 << R_MAR), BSEL_TOS));
        // Empty B select: the bus reads zero and the sum is just the carry.
        run_micro(uinstr(9'h1F0, JAM_Z | JAM_N, SH_NONE, ALU_ADD, 1'b0, 1'b1, 1'b0, 1'b1,
                         (9'b1 << R_CPP) | (9'b1 << R_LV), BSEL_VOID_LO));
        // Inverted zero plus one wraps to zero; all three JAM bits at once.
        send_beat(ACT_MBR, 9'($urandom), rand36(), 8'hFF);
        run_micro(uinstr(9'h000, JAM_C | JAM_N | JAM_Z, SH_NONE, ALU_ADD, 1'b0, 1'b1,
                         1'b1, 1'b1, (9'b1 << R_PC) | (9'b1 << R_MDR), BSEL_VOID_HI));
    endtask

    task automatic test_b_sources();
        bsel_t srcs [6] = '{BSEL_MDR, BSEL_PC, BSEL_SP, BSEL_LV, BSEL_CPP, BSEL_OPC};
        for (int k = 0; k < 6; k++)
            run_micro(uinstr(9'(9'h020 + k), JAM_OFF, SH_NONE, alu_op_t'(k % 4), 1'b1,
                             1'b1, 1'b0, 1'(k), 9'b1 << ((2 * k + 1) % NREGS), srcs[k]));
    endtask

    // Microcycles on written entries for half of the picks, with store writes, MBR loads
    // and the unused action mixed in for the rest.
    task automatic test_random_program(int beats, bit with_idle);
        int stop_at;
        int pick;
        idle_en  = with_idle;
        stop_at  = sent_beats + beats;
        while (sent_beats < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if (!written[upc_q] || $urandom_range(0, 4) == 0)
                    send_beat(ACT_STORE, upc_q, random_uinstr(), 8'($urandom));
                exec_beat();
            end else if (pick < 70) begin
                send_beat(ACT_MBR, 9'($urandom), rand36(), 8'($urandom));
            end else if (pick < 94) begin
                send_beat(ACT_STORE, 9'($urandom), random_uinstr(), 8'($urandom));
            end else begin
                send_beat(ACT_NONE, 9'($urandom), rand36(), 8'($urandom));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = dp_view_t'(m_tdata[M_Z_BIT:0]);
            if (pending_states.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                mismatches++;
            end else begin
                want = pending_states.pop_front();
                for (int i = 0; i < NREGS; i++)
                    if (got.regs[i] !== want.regs[i]) begin
                        $display("%0t: register %0d expected %h got %h", $time, i,
                                 want.regs[i], got.regs[i]);
                        mismatches++;
                    end
                if (got.upc !== want.upc) begin
                    $display("%0t: microaddress expected %h got %h", $time, want.upc, got.upc);
                    mismatches++;
                end
                if (got.neg !== want.neg) begin
                    $display("%0t: N flag expected %b got %b", $time, want.neg, got.neg);
                    mismatches++;
                end
                if (got.zero !== want.zero) begin
                    $display("%0t: Z flag expected %b got %b", $time, want.zero, got.zero);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("stack_machine_microcycle test failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_view();
        test_alu_and_shifter();
        test_b_sources();
        test_random_program(1420, 1'b1);
        test_random_program(400, 1'b0);
        s_tvalid <= 1'b0;
        while (pending_states.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("stack_machine_microcycle test passed");
        else
            $display("stack_machine_microcycle test failed");
        $finish;
    end

endmodule
